[sv/nmg_pkg.sv]
// Shared package of the neighborhood mask generator.
// Holds the fixed-point constants, register and shape codes, and the
// command and status structs between the controller and the datapath.
`default_nettype none

package nmg_pkg;

  // Fixed-point format of every length (unsigned, FRAC_BITS fraction bits).
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned VOX_W     = 16;
  localparam int unsigned OFF_W     = 6;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned DIV_W     = VOX_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_W);

  // One voxel, and the default radius 1.01 rounded to nearest.
  localparam logic [VOX_W-1:0] ONE_FX         = VOX_W'(1 << FRAC_BITS);
  localparam logic [VOX_W-1:0] DEFAULT_RADIUS = VOX_W'(((101 << FRAC_BITS) + 50) / 100);
  localparam logic [VOX_W-1:0] RESET_VOXEL    = VOX_W'(256);
  localparam logic [VOX_W-1:0] RESET_RADIUS   = VOX_W'(256);

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_SHAPE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_VOXEL_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_VOXEL_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOXEL_Z = 3'd3;
  localparam logic [IDX_W-1:0] REG_RADIUS  = 3'd4;
  localparam logic [IDX_W-1:0] REG_HALF_X  = 3'd5;
  localparam logic [IDX_W-1:0] REG_HALF_Y  = 3'd6;
  localparam logic [IDX_W-1:0] REG_HALF_Z  = 3'd7;

  // Shape codes.
  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;
  localparam logic [1:0] SHAPE_DODEC  = 2'd2;
  localparam logic [1:0] SHAPE_OCTA   = 2'd3;

  // Scan phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SCAN = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Axis codes used while the half-extents are divided out.
  localparam logic [1:0] AXIS_I = 2'd0;
  localparam logic [1:0] AXIS_J = 2'd1;
  localparam logic [1:0] AXIS_K = 2'd2;

  // Configuration register file contents.
  typedef struct packed {
    logic [1:0]       shape;
    logic [VOX_W-1:0] voxel_x;
    logic [VOX_W-1:0] voxel_y;
    logic [VOX_W-1:0] voxel_z;
    logic [VOX_W-1:0] radius;
    logic [VOX_W-1:0] half_x;
    logic [VOX_W-1:0] half_y;
    logic [VOX_W-1:0] half_z;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       restart;
    logic       advance;
    logic       div_start;
    logic       bound_wr;
    logic       prod;
    logic       sqr;
    logic       out_load;
    logic       out_origin;
    logic [1:0] axis;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_active;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/neighborhood_mask_generator_unit.sv]
// Top level of the neighborhood mask generator: configuration registers,
// controller and datapath. Depends on nmg_pkg, nmg_ctrl and nmg_datapath.
`default_nettype none

// A restart beat latches the shape, voxel sizes and radius, divides the
// three half-extents one after another in a shared one-bit-per-cycle
// divider, and answers with the origin marked inside. Each advance beat
// answers with the next offset of the raster scan (i fastest, then j,
// then k) through capture, scale by the voxel size, square and shape
// tests, then the final compare into the output register. An advance beat
// while no scan runs is taken and gives no result. The input side takes
// the next beat while a finished result still waits in the output
// register. Register writes take effect at the next restart.
module neighborhood_mask_generator_unit #(
  parameter int unsigned MAX_HALF = 31
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [nmg_pkg::IDX_W-1:0]     cfg_index_i,
  input  wire logic [nmg_pkg::VOX_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [nmg_pkg::OFF_W-1:0]   off_i_o,
  output logic signed [nmg_pkg::OFF_W-1:0]   off_j_o,
  output logic signed [nmg_pkg::OFF_W-1:0]   off_k_o,
  output logic                               inside_res_o,
  output logic                               last_o,
  output logic                               clipped_o
);

  nmg_pkg::cfg_t cfg_q;
  nmg_pkg::cmd_t cmd;
  nmg_pkg::sts_t sts;

  // Configuration register file; always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shape   <= nmg_pkg::SHAPE_SPHERE;
      cfg_q.voxel_x <= nmg_pkg::RESET_VOXEL;
      cfg_q.voxel_y <= nmg_pkg::RESET_VOXEL;
      cfg_q.voxel_z <= nmg_pkg::RESET_VOXEL;
      cfg_q.radius  <= nmg_pkg::RESET_RADIUS;
      cfg_q.half_x  <= '0;
      cfg_q.half_y  <= '0;
      cfg_q.half_z  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nmg_pkg::REG_SHAPE:   cfg_q.shape   <= cfg_data_i[1:0];
        nmg_pkg::REG_VOXEL_X: cfg_q.voxel_x <= cfg_data_i;
        nmg_pkg::REG_VOXEL_Y: cfg_q.voxel_y <= cfg_data_i;
        nmg_pkg::REG_VOXEL_Z: cfg_q.voxel_z <= cfg_data_i;
        nmg_pkg::REG_RADIUS:  cfg_q.radius  <= cfg_data_i;
        nmg_pkg::REG_HALF_X:  cfg_q.half_x  <= cfg_data_i;
        nmg_pkg::REG_HALF_Y:  cfg_q.half_y  <= cfg_data_i;
        nmg_pkg::REG_HALF_Z:  cfg_q.half_z  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer.
  nmg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic, scan state and output register.
  nmg_datapath #(
    .MAX_HALF (MAX_HALF)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .off_i_o      (off_i_o),
    .off_j_o      (off_j_o),
    .off_k_o      (off_k_o),
    .inside_res_o (inside_res_o),
    .last_o       (last_o),
    .clipped_o    (clipped_o)
  );

  // A restart keeps the input side busy while the bounds are divided out.
  a_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && restart_i) |=> !in_ready_o)
    else $error("input taken right after a restart beat");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while full");

  // The divider never finishes in the cycle after it starts.
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished too early");

endmodule

`default_nettype wire

[sv/nmg_div.sv]
// Iterative restoring divider of the neighborhood mask generator.
// One quotient bit per cycle; uses constants from nmg_pkg.
`default_nettype none

module nmg_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [nmg_pkg::DIV_W-1:0]  num_i,
  input  wire logic [nmg_pkg::DIV_W-1:0]  den_i,
  output logic                            done_o,
  output logic [nmg_pkg::DIV_W-1:0]       quo_o
);

  localparam int unsigned W = nmg_pkg::DIV_W;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [nmg_pkg::DCNT_W-1:0]      cnt_q, cnt_d;
  logic [W-1:0]                    rem_q, rem_d;
  logic [W-1:0]                    quo_q, quo_d;
  logic [W-1:0]                    den_q, den_d;
  logic [W:0]                      rem_sh;
  logic                            ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_q, quo_q[W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? W'(rem_sh - {1'b0, den_q}) : W'(rem_sh);
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == nmg_pkg::DCNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and remainder registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[sv/nmg_datapath.sv]
// Datapath of the neighborhood mask generator: latched shape, bounds,
// scan counters, membership arithmetic and output register. Uses nmg_pkg
// and instantiates nmg_div.
`default_nettype none

module nmg_datapath #(
  parameter int unsigned MAX_HALF = 31
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nmg_pkg::cfg_t                 cfg_i,
  input  wire nmg_pkg::cmd_t                 cmd_i,
  output nmg_pkg::sts_t                      sts_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic signed [nmg_pkg::OFF_W-1:0]   off_i_o,
  output logic signed [nmg_pkg::OFF_W-1:0]   off_j_o,
  output logic signed [nmg_pkg::OFF_W-1:0]   off_k_o,
  output logic                               inside_res_o,
  output logic                               last_o,
  output logic                               clipped_o
);

  localparam int unsigned VW   = nmg_pkg::VOX_W;
  localparam int unsigned OW   = nmg_pkg::OFF_W;
  localparam int unsigned BW   = $clog2(MAX_HALF + 1);
  localparam int unsigned CW   = BW + 1;
  localparam int unsigned AW   = CW + VW + 1;
  localparam int unsigned SW   = AW + 2;
  localparam int unsigned SQW  = 2 * AW;
  localparam int unsigned SUMW = SQW + 2;
  localparam logic [BW-1:0] MAXB = BW'(MAX_HALF);

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    logic [SW-1:0] m;
    m = v[SW-1] ? SW'(-v) : SW'(v);
    return m;
  endfunction

  // Latched enumeration parameters.
  logic [1:0]               shape_q;
  logic [VW-1:0]            dvox_q [3];
  logic [VW-1:0]            ext_q  [3];
  logic [VW-1:0]            rad_q;
  logic [2*VW-1:0]          r2_q;
  logic [VW+1:0]            r3_q;

  // Scan state.
  logic [1:0]               phase_q;
  logic                     clip_q;
  logic [BW-1:0]            bound_q [3];
  logic signed [CW-1:0]     cur_q   [3];

  // Item under evaluation and arithmetic stages.
  logic signed [CW-1:0]     eval_q [3];
  logic                     eval_last_q;
  logic signed [AW-1:0]     a_q  [3];
  logic [SQW-1:0]           sq_q [3];
  logic                     dod_ok_q;
  logic                     oct_ok_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [OW-1:0]     out_off_q [3];
  logic                     out_inside_q;
  logic                     out_last_q;
  logic                     out_clip_q;

  // Effective voxel sizes, radius and extents for a restart.
  logic [VW-1:0]            eff_vox [3];
  logic [VW-1:0]            eff_rad;
  logic                     use_default;

  always_comb begin
    use_default = (cfg_i.shape == nmg_pkg::SHAPE_DODEC || cfg_i.shape == nmg_pkg::SHAPE_OCTA)
                  && (cfg_i.radius == '0);
    eff_vox[0] = (cfg_i.voxel_x == '0 || use_default) ? nmg_pkg::ONE_FX : cfg_i.voxel_x;
    eff_vox[1] = (cfg_i.voxel_y == '0 || use_default) ? nmg_pkg::ONE_FX : cfg_i.voxel_y;
    eff_vox[2] = (cfg_i.voxel_z == '0 || use_default) ? nmg_pkg::ONE_FX : cfg_i.voxel_z;
    eff_rad    = use_default ? nmg_pkg::DEFAULT_RADIUS : cfg_i.radius;
  end

  // Shared divider for the three half-extents.
  logic               div_done;
  logic [VW-1:0]      div_quo;

  nmg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (ext_q[cmd_i.axis]),
    .den_i   (dvox_q[cmd_i.axis]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Saturation of the quotient to the largest half-extent.
  logic               sat;
  logic [BW-1:0]      bval;
  logic signed [CW-1:0] bneg;

  always_comb begin
    sat  = (div_quo > VW'(MAX_HALF));
    bval = sat ? MAXB : div_quo[BW-1:0];
    bneg = -$signed({1'b0, bval});
  end

  // Raster step of the scan counters.
  logic                 at_end [3];
  logic                 lst;
  logic signed [CW-1:0] bpos [3];
  logic signed [CW-1:0] bmin [3];

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      bpos[x]   = $signed({1'b0, bound_q[x]});
      bmin[x]   = -bpos[x];
      at_end[x] = (cur_q[x] == bpos[x]);
    end
    lst = at_end[0] && at_end[1] && at_end[2];
  end

  // Latched parameters; r squared and 3r follow the latched radius.
  always_ff @(posedge clk_i) begin
    if (cmd_i.restart) begin
      shape_q <= cfg_i.shape;
      rad_q   <= eff_rad;
      for (int x = 0; x < 3; x++) begin
        dvox_q[x] <= eff_vox[x];
      end
      if (cfg_i.shape == nmg_pkg::SHAPE_BOX) begin
        ext_q[0] <= cfg_i.half_x;
        ext_q[1] <= cfg_i.half_y;
        ext_q[2] <= cfg_i.half_z;
      end else begin
        for (int x = 0; x < 3; x++) begin
          ext_q[x] <= eff_rad;
        end
      end
    end
    r2_q <= rad_q * rad_q;
    r3_q <= {2'b00, rad_q} + {1'b0, rad_q, 1'b0};
  end

  // Scan phase, bounds and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nmg_pkg::PH_IDLE;
      clip_q  <= 1'b0;
      for (int x = 0; x < 3; x++) begin
        bound_q[x] <= '0;
        cur_q[x]   <= '0;
      end
    end else begin
      if (cmd_i.restart) begin
        phase_q <= nmg_pkg::PH_SCAN;
        clip_q  <= 1'b0;
      end else if (cmd_i.bound_wr) begin
        bound_q[cmd_i.axis] <= bval;
        cur_q[cmd_i.axis]   <= bneg;
        clip_q              <= clip_q | sat;
      end else if (cmd_i.advance) begin
        if (lst) begin
          phase_q <= nmg_pkg::PH_DONE;
        end else if (!at_end[0]) begin
          cur_q[0] <= cur_q[0] + 1'b1;
        end else begin
          cur_q[0] <= bmin[0];
          if (!at_end[1]) begin
            cur_q[1] <= cur_q[1] + 1'b1;
          end else begin
            cur_q[1] <= bmin[1];
            cur_q[2] <= cur_q[2] + 1'b1;
          end
        end
      end
    end
  end

  // Shape tests on the scaled offsets. A scaled offset never exceeds
  // MAX_HALF times the largest voxel, so its magnitude fits in AW-2 bits
  // and only that magnitude is squared.
  logic signed [SW-1:0] ea, eb, ec;
  logic [SW-1:0]        rr;
  logic [SW:0]          r3x;
  logic                 dod_ok, oct_ok;
  logic [AW-3:0]        amag [3];
  logic [2*AW-5:0]      asq  [3];

  always_comb begin
    ea  = SW'(a_q[0]);
    eb  = SW'(a_q[1]);
    ec  = SW'(a_q[2]);
    rr  = SW'(rad_q);
    r3x = (SW + 1)'(r3_q);
    dod_ok = (mag(ea + eb) <= rr) && (mag(ea - eb) <= rr) &&
             (mag(ea + ec) <= rr) && (mag(ea - ec) <= rr) &&
             (mag(eb + ec) <= rr) && (mag(eb - ec) <= rr);
    oct_ok = (mag(ea) <= rr) && (mag(eb) <= rr) && (mag(ec) <= rr) &&
             ({mag(ea + eb + ec), 1'b0} <= r3x) &&
             ({mag(ea - eb + ec), 1'b0} <= r3x) &&
             ({mag(ea + eb - ec), 1'b0} <= r3x) &&
             ({mag(ea - eb - ec), 1'b0} <= r3x);
    for (int x = 0; x < 3; x++) begin
      amag[x] = a_q[x][AW-1] ? (AW - 2)'(-a_q[x]) : (AW - 2)'(a_q[x]);
      asq[x]  = amag[x] * amag[x];
    end
  end

  // Evaluation pipeline: capture, scale, square.
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      for (int x = 0; x < 3; x++) begin
        eval_q[x] <= cur_q[x];
      end
      eval_last_q <= lst;
    end
    if (cmd_i.prod) begin
      for (int x = 0; x < 3; x++) begin
        a_q[x] <= AW'(eval_q[x]) * AW'($signed({1'b0, dvox_q[x]}));
      end
    end
    if (cmd_i.sqr) begin
      for (int x = 0; x < 3; x++) begin
        sq_q[x] <= SQW'(asq[x]);
      end
      dod_ok_q <= dod_ok;
      oct_ok_q <= oct_ok;
    end
  end

  // Final decision for the captured offset.
  logic [SUMW-1:0]          dist2;
  logic                     is_origin;
  logic                     shape_ok;
  logic signed [CW+OW-1:0]  wide [3];

  always_comb begin
    dist2     = SUMW'(sq_q[0]) + SUMW'(sq_q[1]) + SUMW'(sq_q[2]);
    is_origin = (eval_q[0] == '0) && (eval_q[1] == '0) && (eval_q[2] == '0);
    case (shape_q)
      nmg_pkg::SHAPE_SPHERE: shape_ok = (dist2 <= SUMW'(r2_q));
      nmg_pkg::SHAPE_BOX:    shape_ok = 1'b1;
      nmg_pkg::SHAPE_DODEC:  shape_ok = dod_ok_q;
      default:               shape_ok = oct_ok_q;
    endcase
    for (int x = 0; x < 3; x++) begin
      wide[x] = (CW + OW)'(eval_q[x]);
    end
  end

  // Output register; the restart beat carries the origin marked inside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_clip_q <= clip_q;
      if (cmd_i.out_origin) begin
        for (int x = 0; x < 3; x++) begin
          out_off_q[x] <= '0;
        end
        out_inside_q <= 1'b1;
        out_last_q   <= 1'b0;
      end else begin
        for (int x = 0; x < 3; x++) begin
          out_off_q[x] <= wide[x][OW-1:0];
        end
        out_inside_q <= !is_origin && shape_ok;
        out_last_q   <= eval_last_q;
      end
    end
  end

  assign sts_o.div_done    = div_done;
  assign sts_o.scan_active = (phase_q == nmg_pkg::PH_SCAN);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign off_i_o      = out_off_q[0];
  assign off_j_o      = out_off_q[1];
  assign off_k_o      = out_off_q[2];
  assign inside_res_o = out_inside_q;
  assign last_o       = out_last_q;
  assign clipped_o    = out_clip_q;

endmodule

`default_nettype wire

[sv/nmg_ctrl.sv]
// Controller of the neighborhood mask generator: sequences the restart
// divisions and the evaluation steps. Uses the structs of nmg_pkg.
`default_nettype none

module nmg_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic           restart_i,
  output logic                in_ready_o,
  input  wire nmg_pkg::sts_t  sts_i,
  output nmg_pkg::cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DWAIT  = 3'd2;
  localparam logic [2:0] S_PROD   = 3'd3;
  localparam logic [2:0] S_SQR    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       origin_q, origin_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    origin_d = origin_q;
    cmd_o    = '0;
    cmd_o.axis       = axis_q;
    cmd_o.out_origin = origin_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (restart_i) begin
            cmd_o.restart = 1'b1;
            axis_d        = nmg_pkg::AXIS_I;
            origin_d      = 1'b1;
            state_d       = S_DSTART;
          end else if (sts_i.scan_active) begin
            cmd_o.advance = 1'b1;
            origin_d      = 1'b0;
            state_d       = S_PROD;
          end
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.bound_wr = 1'b1;
          if (axis_q == nmg_pkg::AXIS_K) begin
            state_d = S_FIN;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_DSTART;
          end
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      axis_q   <= nmg_pkg::AXIS_I;
      origin_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      origin_q <= origin_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of neighborhood_mask_generator_unit: random and directed
// restart and advance beats, checked field by field against a scoreboard prediction.
// Depends on nmg_pkg and the unit's RTL; it reads no files.

module testbench;

  localparam int     MAX_HALF        = 31;
  localparam int     FRAC            = 8;
  localparam longint UNIT_FX         = longint'(1) << FRAC;
  localparam longint FALLBACK_RADIUS = ((longint'(101) << FRAC) + 50) / 100;
  localparam int     RANDOM_POINTS   = 900;
  localparam int     DRAIN_CYCLES    = 80;
  localparam int     SETTLE_LIMIT    = 5000;
  localparam int     CYCLE_LIMIT     = 400000;

  // One offset as the unit reports it.
  typedef struct packed {
    logic signed [nmg_pkg::OFF_W-1:0] off_i;
    logic signed [nmg_pkg::OFF_W-1:0] off_j;
    logic signed [nmg_pkg::OFF_W-1:0] off_k;
    logic                             in_mask;
    logic                             last;
    logic                             clipped;
  } mask_point_t;

  // Shadow of the register file and the scan, with the queue of offsets still owed.
  class offset_scoreboard;
    logic [1:0]   cfg_shape;
    logic [15:0]  cfg_vox [3];
    logic [15:0]  cfg_radius;
    logic [15:0]  cfg_half [3];
    logic [1:0]   scan_shape;
    longint       scan_vox [3];
    longint       scan_radius;
    int           bound [3];
    int           pos [3];
    logic [1:0]   phase;
    logic         clip_flag;
    mask_point_t  expected_points [$];
    int           mismatches;

    function new();
      cfg_shape   = nmg_pkg::SHAPE_SPHERE;
      cfg_radius  = 16'd256;
      scan_shape  = nmg_pkg::SHAPE_SPHERE;
      scan_radius = 0;
      phase       = nmg_pkg::PH_IDLE;
      clip_flag   = 1'b0;
      mismatches  = 0;
      for (int n = 0; n < 3; n++) begin
        cfg_vox[n]  = 16'd256;
        cfg_half[n] = 16'd0;
        scan_vox[n] = 0;
        bound[n]    = 0;
        pos[n]      = 0;
      end
    endfunction

    function void write_reg(logic [nmg_pkg::IDX_W-1:0] idx, logic [nmg_pkg::VOX_W-1:0] data);
      case (idx)
        nmg_pkg::REG_SHAPE:   cfg_shape   = data[1:0];
        nmg_pkg::REG_VOXEL_X: cfg_vox[0]  = data;
        nmg_pkg::REG_VOXEL_Y: cfg_vox[1]  = data;
        nmg_pkg::REG_VOXEL_Z: cfg_vox[2]  = data;
        nmg_pkg::REG_RADIUS:  cfg_radius  = data;
        nmg_pkg::REG_HALF_X:  cfg_half[0] = data;
        nmg_pkg::REG_HALF_Y:  cfg_half[1] = data;
        nmg_pkg::REG_HALF_Z:  cfg_half[2] = data;
        default: ;
      endcase
    endfunction

    // Whole voxels that fit in an extent, saturated at the largest half-extent.
    function int half_extent(longint ext, longint vox);
      longint q;
      q = ext / vox;
      if (q > MAX_HALF) begin
        q = MAX_HALF;
        clip_flag = 1'b1;
      end
      return int'(q);
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Membership of one offset in the latched shape; the origin never counts here.
    function bit in_shape(int i, int j, int k);
      longint a, b, c, r;
      a = longint'(i) * scan_vox[0];
      b = longint'(j) * scan_vox[1];
      c = longint'(k) * scan_vox[2];
      r = scan_radius;
      if (i == 0 && j == 0 && k == 0) return 1'b0;
      case (scan_shape)
        nmg_pkg::SHAPE_SPHERE: return a * a + b * b + c * c <= r * r;
        nmg_pkg::SHAPE_BOX:    return 1'b1;
        nmg_pkg::SHAPE_DODEC:
          return mag(a + b) <= r && mag(a - b) <= r && mag(a + c) <= r &&
                 mag(a - c) <= r && mag(b + c) <= r && mag(b - c) <= r;
        default:
          return mag(a) <= r && mag(b) <= r && mag(c) <= r &&
                 2 * mag(a + b + c) <= 3 * r && 2 * mag(a - b + c) <= 3 * r &&
                 2 * mag(a + b - c) <= 3 * r && 2 * mag(a - b - c) <= 3 * r;
      endcase
    endfunction

    // Predicts the answer to an accepted input beat; returns 1 if one is owed.
    function bit predict_offset(logic restart_bit);
      longint      vox [3];
      longint      rad;
      longint      ext;
      mask_point_t pt;
      bit          at_end;
      if (restart_bit) begin
        for (int n = 0; n < 3; n++) vox[n] = (cfg_vox[n] == 0) ? UNIT_FX : longint'(cfg_vox[n]);
        rad        = longint'(cfg_radius);
        scan_shape = cfg_shape;
        clip_flag  = 1'b0;
        // A zero radius falls back to the six-neighbor set for these two shapes.
        if ((scan_shape == nmg_pkg::SHAPE_DODEC || scan_shape == nmg_pkg::SHAPE_OCTA) &&
            rad == 0) begin
          for (int n = 0; n < 3; n++) vox[n] = UNIT_FX;
          rad = FALLBACK_RADIUS;
        end
        for (int n = 0; n < 3; n++) begin
          ext         = (scan_shape == nmg_pkg::SHAPE_BOX) ? longint'(cfg_half[n]) : rad;
          bound[n]    = half_extent(ext, vox[n]);
          scan_vox[n] = vox[n];
          pos[n]      = -bound[n];
        end
        scan_radius = rad;
        phase       = nmg_pkg::PH_SCAN;
        pt.off_i    = '0;
        pt.off_j    = '0;
        pt.off_k    = '0;
        pt.in_mask  = 1'b1;
        pt.last     = 1'b0;
        pt.clipped  = clip_flag;
        expected_points.push_back(pt);
        return 1'b1;
      end
      if (phase != nmg_pkg::PH_SCAN) return 1'b0;
      at_end     = (pos[0] == bound[0] && pos[1] == bound[1] && pos[2] == bound[2]);
      pt.off_i   = nmg_pkg::OFF_W'(pos[0]);
      pt.off_j   = nmg_pkg::OFF_W'(pos[1]);
      pt.off_k   = nmg_pkg::OFF_W'(pos[2]);
      pt.in_mask = in_shape(pos[0], pos[1], pos[2]);
      pt.last    = at_end;
      pt.clipped = clip_flag;
      expected_points.push_back(pt);
      // Raster order: i fastest, then j, then k.
      if (at_end) begin
        phase = nmg_pkg::PH_DONE;
      end else if (pos[0] < bound[0]) begin
        pos[0]++;
      end else begin
        pos[0] = -bound[0];
        if (pos[1] < bound[1]) begin
          pos[1]++;
        end else begin
          pos[1] = -bound[1];
          pos[2]++;
        end
      end
      return 1'b1;
    endfunction

    // Offsets the current scan still has to report.
    function int points_left();
      int span_i, span_j, total, done;
      if (phase != nmg_pkg::PH_SCAN) return 0;
      span_i = 2 * bound[0] + 1;
      span_j = 2 * bound[1] + 1;
      total  = span_i * span_j * (2 * bound[2] + 1);
      done   = ((pos[2] + bound[2]) * span_j + pos[1] + bound[1]) * span_i + pos[0] + bound[0];
      return total - done;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(mask_point_t got);
      mask_point_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: beat with nothing expected, actual (%0d,%0d,%0d) in=%0b last=%0b clip=%0b",
                 $time, got.off_i, got.off_j, got.off_k, got.in_mask, got.last, got.clipped);
        mismatches++;
        return;
      end
      want = expected_points.pop_front();
      compare_field("off_i", want.off_i, got.off_i);
      compare_field("off_j", want.off_j, got.off_j);
      compare_field("off_k", want.off_k, got.off_k);
      compare_field("inside_res", want.in_mask, got.in_mask);
      compare_field("last", want.last, got.last);
      compare_field("clipped", want.clipped, got.clipped);
    endfunction

    function void close_out();
      if (expected_points.size() != 0) begin
        $display("%0t: %0d expected beats never arrived", $time, expected_points.size());
        mismatches += expected_points.size();
      end
    endfunction
  endclass

  logic                             clk       = 1'b0;
  logic                             rst_n     = 1'b0;
  logic                             cfg_valid = 1'b0;
  logic [nmg_pkg::IDX_W-1:0]        cfg_index = '0;
  logic [nmg_pkg::VOX_W-1:0]        cfg_data  = '0;
  logic                             in_valid  = 1'b0;
  logic                             restart   = 1'b0;
  logic                             out_ready = 1'b0;
  logic                             cfg_ready;
  logic                             in_ready;
  logic                             out_valid;
  logic signed [nmg_pkg::OFF_W-1:0] off_i;
  logic signed [nmg_pkg::OFF_W-1:0] off_j;
  logic signed [nmg_pkg::OFF_W-1:0] off_k;
  logic                             inside_res;
  logic                             last;
  logic                             clipped;

  // While set, neither side idles.
  bit                      calm = 1'b0;
  int                      points_sent = 0;
  offset_scoreboard        board;

  neighborhood_mask_generator_unit #(
    .MAX_HALF(MAX_HALF)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .restart_i   (restart),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .off_i_o     (off_i),
    .off_j_o     (off_j),
    .off_k_o     (off_k),
    .inside_res_o(inside_res),
    .last_o      (last),
    .clipped_o   (clipped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Writes all eight registers in index order; the shape word carries random upper bits.
  task automatic load_config(input logic [1:0] shape, input logic [15:0] vx, input logic [15:0] vy,
                             input logic [15:0] vz, input logic [15:0] rad, input logic [15:0] hx,
                             input logic [15:0] hy, input logic [15:0] hz);
    logic [nmg_pkg::IDX_W-1:0] idx_list [8];
    logic [nmg_pkg::VOX_W-1:0] vals [8];
    idx_list = '{nmg_pkg::REG_SHAPE, nmg_pkg::REG_VOXEL_X, nmg_pkg::REG_VOXEL_Y,
                 nmg_pkg::REG_VOXEL_Z, nmg_pkg::REG_RADIUS, nmg_pkg::REG_HALF_X,
                 nmg_pkg::REG_HALF_Y, nmg_pkg::REG_HALF_Z};
    vals     = '{{14'($urandom), shape}, vx, vy, vz, rad, hx, hy, hz};
    for (int n = 0; n < 8; n++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[n];
      cfg_data  <= vals[n];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.write_reg(idx_list[n], vals[n]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Sends one input beat, with occasional idle cycles ahead of it while calm is clear.
  task automatic send_beat(input logic restart_bit);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= restart_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (board.predict_offset(restart_bit)) points_sent++;
  endtask

  // Waits for every owed beat, then long enough for a restart still in flight.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (board.pending() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] random_length();
    return 16'($urandom) >> $urandom_range(0, 15);
  endfunction

  // Picks a configuration; most keep the scan to a few voxels per axis.
  task automatic random_config();
    logic [1:0]  shape;
    logic [15:0] vox [3];
    logic [15:0] half [3];
    logic [15:0] rad;
    int          target;
    int          step;
    int          pick;
    shape = 2'($urandom);
    rad   = random_length();
    for (int n = 0; n < 3; n++) begin
      vox[n]  = 16'($urandom);
      half[n] = 16'($urandom);
    end
    case ($urandom_range(0, 11))
      0: rad = '0;
      1: begin
        rad = 16'($urandom_range(0, 1023));
        for (int n = 0; n < 3; n++) begin
          vox[n]  = '0;
          half[n] = 16'($urandom_range(0, 1023));
        end
      end
      2: begin
        rad = 16'hFFFF;
        for (int n = 0; n < 3; n++) begin
          half[n] = 16'hFFFF;
          if ($urandom_range(0, 1) == 0) vox[n] = 16'hFFFF;
        end
      end
      3: vox[$urandom_range(0, 2)] = 16'd1;
      default: begin
        if (rad == 0) rad = 16'd1;
        for (int n = 0; n < 3; n++) begin
          target = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
          if (shape == nmg_pkg::SHAPE_BOX) begin
            vox[n] = random_length();
            if (vox[n] == 0) vox[n] = 16'd1;
            pick = int'(vox[n]) * target + $urandom_range(0, int'(vox[n]) - 1);
            half[n] = (pick > 65535) ? 16'hFFFF : 16'(pick);
          end else begin
            // A voxel just over radius/(target+1) leaves about target voxels per side.
            step = int'(rad) / ((target + 1) * (target + 2));
            pick = int'(rad) / (target + 1) + $urandom_range(1, (step < 1) ? 1 : step);
            vox[n] = (pick > 65535) ? 16'hFFFF : 16'(pick);
          end
        end
      end
    endcase
    load_config(shape, vox[0], vox[1], vox[2], rad, half[0], half[1], half[2]);
  endtask

  // One enumeration: mostly complete scans, sometimes abandoned by a fresh restart.
  task automatic run_scan();
    int left;
    // A stray advance ahead of the restart; it is dropped unless a scan was left open.
    if ($urandom_range(0, 7) == 0) send_beat(1'b0);
    send_beat(1'b1);
    left = board.points_left();
    if (left <= 150 && $urandom_range(0, 5) != 0) begin
      repeat (left) send_beat(1'b0);
      repeat ($urandom_range(0, 2)) send_beat(1'b0);
    end else begin
      repeat ($urandom_range(1, (left < 40) ? left : 40)) send_beat(1'b0);
      send_beat(1'b1);
      left = board.points_left();
      repeat ($urandom_range(0, (left < 20) ? left : 20)) send_beat(1'b0);
    end
  endtask

  // Output side: checks every accepted beat and stalls now and then.
  initial begin : result_monitor
    mask_point_t got;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.off_i   = off_i;
        got.off_j   = off_j;
        got.off_k   = off_k;
        got.in_mask = inside_res;
        got.last    = last;
        got.clipped = clipped;
        board.check_result(got);
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 6);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Advance with no scan running, then a partial scan at the reset settings.
    send_beat(1'b0);
    send_beat(1'b1);
    repeat (3) send_beat(1'b0);
    settle();

    // Sphere of zero radius: the origin alone, reported inside by the restart and outside by the scan, then nothing.
    load_config(nmg_pkg::SHAPE_SPHERE, 16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    settle();

    // Dodecahedron default with zero voxel sizes, restarted part way.
    load_config(nmg_pkg::SHAPE_DODEC, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    settle();

    // Octahedron default overrides odd voxel sizes.
    load_config(nmg_pkg::SHAPE_OCTA, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(1'b1);
    repeat (3) send_beat(1'b0);
    settle();

    // Box saturated on every axis.
    load_config(nmg_pkg::SHAPE_BOX, 16'd1, 16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    settle();

    // Box of zero extent: one last offset, then an ignored advance.
    load_config(nmg_pkg::SHAPE_BOX, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    settle();

    // Sphere with the largest radius and voxels.
    load_config(nmg_pkg::SHAPE_SPHERE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0,
                16'd0);
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    settle();

    // Random enumerations, with one stretch free of idle cycles.
    points_sent = 0;
    while (points_sent < RANDOM_POINTS) begin
      calm = (points_sent >= 300 && points_sent < 500);
      random_config();
      run_scan();
      settle();
    end
    calm = 1'b0;
    settle();
    board.close_out();

    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
